// ===== src/jts_pkg.sv =====
// jts_pkg: shared action codes, bus types and sizes for the json token serialiser
// depends on nothing; used by every module of the block
package jts_pkg;

   localparam logic [3:0] ACT_OPEN_OBJ  = 4'd0;
   localparam logic [3:0] ACT_CLOSE_OBJ = 4'd1;
   localparam logic [3:0] ACT_OPEN_ARR  = 4'd2;
   localparam logic [3:0] ACT_CLOSE_ARR = 4'd3;
   localparam logic [3:0] ACT_KEY       = 4'd4;
   localparam logic [3:0] ACT_STRING    = 4'd5;
   localparam logic [3:0] ACT_INT       = 4'd6;
   localparam logic [3:0] ACT_BOOL      = 4'd7;
   localparam logic [3:0] ACT_NULL      = 4'd8;
   localparam logic [3:0] ACT_RAW       = 4'd9;
   localparam logic [3:0] ACT_RESET     = 4'd10;

   localparam int NUM_DIGITS = 20;
   localparam int NUM_SLOTS  = 30;
   localparam int DIGIT_SLOT = 10;
   localparam int NUM_BITS   = 64;

   typedef logic [4:0] slot_type;

   typedef struct packed {
      logic     load;
      logic     dab_step;
      logic     out_load;
      slot_type slot;
   } cmd_type;

   typedef struct packed {
      logic is_int;
      logic slot_on;
      logic more;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) r = 8'h30 + {4'h0, nib};
      else             r = 8'h57 + {4'h0, nib};
      return r;
   endfunction

endpackage

// ===== src/jts_datapath.sv =====
// jts_datapath: item registers, comma flag, double-dabble converter, slot byte mux, output word
// depends on jts_pkg
module jts_datapath import jts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [3:0]       req_action,
   input  logic [7:0]       req_char_byte,
   input  logic             req_byte_valid,
   input  logic             req_first_byte,
   input  logic             req_last_byte,
   input  logic signed [63:0] req_number,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_out
);

   logic [3:0]  act_ff;
   logic [7:0]  chr_ff;
   logic        vld_ff, fst_ff, lst_ff, sep_ff, neg_ff, nz_ff;
   logic        comma_ff, comma_in;
   logic [63:0] mag_ff, mag_in;
   logic [4*NUM_DIGITS-1:0] bcd_ff, bcd_in;
   logic [7:0]  byte_ff;
   logic        last_ff;

   logic [NUM_SLOTS-1:0] mask;
   logic [NUM_DIGITS-1:0] dig_on;
   logic [7:0]  esc, cur_byte;
   logic        is_short, is_ctrl;
   logic [63:0] raw;

   assign raw = req_number;

   // comma flag follows the token at acceptance
   always_comb begin
      comma_in = comma_ff;
      case (req_action)
         ACT_OPEN_OBJ, ACT_OPEN_ARR:   comma_in = 1'b0;
         ACT_CLOSE_OBJ, ACT_CLOSE_ARR: comma_in = 1'b1;
         ACT_KEY, ACT_STRING, ACT_RAW: begin
            if (req_first_byte) comma_in = 1'b0;
            if (req_last_byte)  comma_in = (req_action != ACT_KEY);
         end
         ACT_INT, ACT_BOOL, ACT_NULL:  comma_in = 1'b1;
         ACT_RESET:                    comma_in = 1'b0;
         default:                      comma_in = comma_ff;
      endcase
   end

   // double dabble, one bit per step
   always_comb begin
      bcd_in = bcd_ff;
      mag_in = mag_ff;
      if (cmd.load) begin
         bcd_in = '0;
         mag_in = raw[63] ? (~raw + 64'd1) : raw;
      end else if (cmd.dab_step) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_ff[4*i +: 4] > 4'd4) bcd_in[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
            else                         bcd_in[4*i +: 4] = bcd_ff[4*i +: 4];
         end
         bcd_in = {bcd_in[4*NUM_DIGITS-2:0], mag_ff[63]};
         mag_in = {mag_ff[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comma_ff <= 1'b0;
      end else if (cmd.load) begin
         comma_ff <= comma_in;
      end
      if (cmd.load) begin
         act_ff <= req_action;
         chr_ff <= req_char_byte;
         vld_ff <= req_byte_valid;
         fst_ff <= req_first_byte;
         lst_ff <= req_last_byte;
         sep_ff <= comma_ff;
         neg_ff <= raw[63];
         nz_ff  <= (raw != 64'd0);
      end
      bcd_ff <= bcd_in;
      mag_ff <= mag_in;
      if (cmd.out_load) begin
         byte_ff <= cur_byte;
         last_ff <= ~status.more;
      end
   end

   // escape classification
   always_comb begin
      is_short = 1'b1;
      case (chr_ff)
         8'h22:   esc = 8'h22;
         8'h5c:   esc = 8'h5c;
         8'h08:   esc = 8'h62;
         8'h0c:   esc = 8'h66;
         8'h0a:   esc = 8'h6e;
         8'h0d:   esc = 8'h72;
         8'h09:   esc = 8'h74;
         default: begin esc = 8'h00; is_short = 1'b0; end
      endcase
      is_ctrl = ~is_short & (chr_ff < 8'h20);
   end

   // leading zero suppression, least significant digit always shown
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         seen = seen | (bcd_ff[4*(NUM_DIGITS-1-i) +: 4] != 4'd0) | (i == NUM_DIGITS-1);
         dig_on[i] = seen;
      end
   end

   always_comb begin
      mask = '0;
      case (act_ff)
         ACT_OPEN_OBJ, ACT_OPEN_ARR: begin
            mask[0] = sep_ff;
            mask[1] = 1'b1;
         end
         ACT_CLOSE_OBJ, ACT_CLOSE_ARR: mask[1] = 1'b1;
         ACT_KEY, ACT_STRING: begin
            mask[0] = fst_ff & sep_ff;
            mask[1] = fst_ff;
            mask[2] = vld_ff;
            mask[3] = vld_ff & (is_short | is_ctrl);
            mask[4] = vld_ff & is_ctrl;
            mask[5] = vld_ff & is_ctrl;
            mask[6] = vld_ff & is_ctrl;
            mask[7] = vld_ff & is_ctrl;
            mask[8] = lst_ff;
            mask[9] = lst_ff & (act_ff == ACT_KEY);
         end
         ACT_INT: begin
            mask[0] = sep_ff;
            mask[1] = neg_ff;
            mask[DIGIT_SLOT +: NUM_DIGITS] = dig_on;
         end
         ACT_BOOL: begin
            mask[0]   = sep_ff;
            mask[4:1] = 4'hf;
            mask[5]   = ~nz_ff;
         end
         ACT_NULL: begin
            mask[0]   = sep_ff;
            mask[4:1] = 4'hf;
         end
         ACT_RAW: begin
            mask[0] = fst_ff & sep_ff;
            mask[2] = vld_ff;
         end
         default: mask = '0;
      endcase
   end

   always_comb begin
      cur_byte = 8'h2c;
      if (cmd.slot >= slot_type'(DIGIT_SLOT)) begin
         cur_byte = 8'h30 + {4'h0, bcd_ff[4*(NUM_SLOTS-1-32'(cmd.slot)) +: 4]};
      end else begin
         case (cmd.slot)
            5'd0: cur_byte = 8'h2c;
            5'd1: begin
               case (act_ff)
                  ACT_OPEN_OBJ:  cur_byte = 8'h7b;
                  ACT_CLOSE_OBJ: cur_byte = 8'h7d;
                  ACT_OPEN_ARR:  cur_byte = 8'h5b;
                  ACT_CLOSE_ARR: cur_byte = 8'h5d;
                  ACT_INT:       cur_byte = 8'h2d;
                  ACT_BOOL:      cur_byte = nz_ff ? 8'h74 : 8'h66;
                  ACT_NULL:      cur_byte = 8'h6e;
                  default:       cur_byte = 8'h22;
               endcase
            end
            5'd2: begin
               if (act_ff == ACT_BOOL)      cur_byte = nz_ff ? 8'h72 : 8'h61;
               else if (act_ff == ACT_NULL) cur_byte = 8'h75;
               else if (act_ff == ACT_RAW)  cur_byte = chr_ff;
               else if (is_short | is_ctrl) cur_byte = 8'h5c;
               else                         cur_byte = chr_ff;
            end
            5'd3: begin
               if (act_ff == ACT_BOOL)      cur_byte = nz_ff ? 8'h75 : 8'h6c;
               else if (act_ff == ACT_NULL) cur_byte = 8'h6c;
               else if (is_short)           cur_byte = esc;
               else                         cur_byte = 8'h75;
            end
            5'd4: begin
               if (act_ff == ACT_BOOL)      cur_byte = nz_ff ? 8'h65 : 8'h73;
               else if (act_ff == ACT_NULL) cur_byte = 8'h6c;
               else                         cur_byte = 8'h30;
            end
            5'd5: cur_byte = (act_ff == ACT_BOOL) ? 8'h65 : 8'h30;
            5'd6: cur_byte = hex_char(chr_ff[7:4]);
            5'd7: cur_byte = hex_char(chr_ff[3:0]);
            5'd8: cur_byte = 8'h22;
            5'd9: cur_byte = 8'h3a;
            default: cur_byte = 8'h2c;
         endcase
      end
   end

   assign status.is_int  = (act_ff == ACT_INT);
   assign status.slot_on = mask[cmd.slot];
   assign status.more    = ((mask >> cmd.slot) >> 1) != '0;

   assign rsp_out_byte = byte_ff;
   assign rsp_last_out = last_ff;

endmodule

// ===== src/jts_controller.sv =====
// jts_controller: sequencer for load, conversion and slot walk; owns the handshakes
// depends on jts_pkg
module jts_controller import jts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_CONV = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   slot_type   slot_ff, slot_in;
   logic       vld_ff, vld_in;
   logic       out_free;

   assign out_free  = ~vld_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      cmd.load     = 1'b0;
      cmd.dab_step = 1'b0;
      cmd.out_load = 1'b0;
      cmd.slot     = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cnt_in   = '0;
            slot_in  = '0;
            state_in = status.is_int ? ST_CONV : ST_EMIT;
         end
         ST_CONV: begin
            cmd.dab_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_BITS-1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_on) begin
               if (out_free) begin
                  cmd.out_load = 1'b1;
                  if (!status.more) state_in = ST_IDLE;
                  else              slot_in  = slot_ff + 5'd1;
               end
            end else if (!status.more) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.out_load)   vld_in = 1'b1;
      else if (rsp_ready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      cnt_ff  <= cnt_in;
      slot_ff <= slot_in;
   end

   assign rsp_valid = vld_ff;

endmodule

// ===== src/json_token_serializer_unit.sv =====
// json_token_serializer_unit: top level of the json token serialiser
// depends on jts_pkg, jts_controller, jts_datapath
//
// usage
//   req_* carries one token event per word (valid/ready); rsp_* returns the
//   serialised text one byte per word, rsp_last_out marking the final byte
//   of that event. events that produce nothing (reset action, unused codes,
//   an empty raw fragment that owes no comma) return no words at all
// sequencing
//   one event at a time. after acceptance a set-up state, then the output
//   slots are walked in order: up to 10 slots for non-integer tokens. an
//   integer first runs a 64-step double-dabble conversion (one bit a cycle)
//   and then walks 30 slots
// stalls
//   the result word sits in an output register; while it waits the slot walk
//   holds, and the next event is taken as soon as the last byte is registered
// reset
//   synchronous, active high: clears the comma flag, the sequencer and the
//   result valid
module json_token_serializer_unit import jts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_action,
   input  logic [7:0]        req_char_byte,
   input  logic              req_byte_valid,
   input  logic              req_first_byte,
   input  logic              req_last_byte,
   input  logic signed [63:0] req_number,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_out
);

   cmd_type    cmd;
   status_type status;

   // sequencer: handshakes, conversion count, slot pointer
   jts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // item registers, comma flag, converter and output word
   jts_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_char_byte  (req_char_byte),
      .req_byte_valid (req_byte_valid),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_number     (req_number),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

// ===== src/jts_checker.sv =====
// jts_checker: port-level assertions for json_token_serializer_unit
// depends on jts_pkg; bound to the top level below
module jts_checker import jts_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_out
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_out))
      else $error("result word changed under stall");

   // nothing is shown straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // one event at a time: no second acceptance on the next edge
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted two words back to back");

endmodule

bind json_token_serializer_unit jts_checker u_jts_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last_out (rsp_last_out)
);
